[design/rttyf_pkg.sv]
// Package with shared types, constants and the ITA2 lookup table of the RTTY framer.
`default_nettype none

package rttyf_pkg;

  localparam int unsigned IDLE_CODES_DEF = 16;
  localparam int unsigned REP_W          = 5;
  localparam int unsigned Q_DEPTH        = 2;

  localparam logic [4:0] CODE_LETTERS = 5'd31;
  localparam logic [4:0] CODE_FIGURES = 5'd27;
  localparam logic [4:0] CODE_CR      = 5'd8;
  localparam logic [4:0] CODE_LF      = 5'd2;

  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_AT      = 8'h40;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
  localparam logic [7:0] CASE_MASK    = 8'h5F;
  localparam logic [7:0] TABLE_BASE   = 8'h20;
  localparam logic [7:0] TABLE_END    = 8'h5B;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_IDLE = 1'b1;

  // One queued job: code_a sent rep times, then code_b once if has_b.
  typedef struct packed {
    logic [4:0]       code_a;
    logic [REP_W-1:0] rep;
    logic             has_b;
    logic [4:0]       code_b;
  } rttyf_job_t;

  // ITA2 code for characters 0x20 to 0x5A; index is the byte minus 0x20.
  function automatic logic [4:0] ita2_lookup(input logic [5:0] idx);
    logic [4:0] code;
    unique case (idx)
      6'd0:  code = 5'd4;   6'd1:  code = 5'd13;  6'd2:  code = 5'd17;
      6'd3:  code = 5'd20;  6'd4:  code = 5'd9;   6'd5:  code = 5'd0;
      6'd6:  code = 5'd26;  6'd7:  code = 5'd11;  6'd8:  code = 5'd15;
      6'd9:  code = 5'd18;  6'd10: code = 5'd0;   6'd11: code = 5'd0;
      6'd12: code = 5'd12;  6'd13: code = 5'd3;   6'd14: code = 5'd28;
      6'd15: code = 5'd29;  6'd16: code = 5'd22;  6'd17: code = 5'd23;
      6'd18: code = 5'd19;  6'd19: code = 5'd1;   6'd20: code = 5'd10;
      6'd21: code = 5'd16;  6'd22: code = 5'd21;  6'd23: code = 5'd7;
      6'd24: code = 5'd6;   6'd25: code = 5'd24;  6'd26: code = 5'd14;
      6'd27: code = 5'd30;  6'd28: code = 5'd0;   6'd29: code = 5'd0;
      6'd30: code = 5'd0;   6'd31: code = 5'd25;  6'd32: code = 5'd0;
      6'd33: code = 5'd3;   6'd34: code = 5'd25;  6'd35: code = 5'd14;
      6'd36: code = 5'd9;   6'd37: code = 5'd1;   6'd38: code = 5'd13;
      6'd39: code = 5'd26;  6'd40: code = 5'd20;  6'd41: code = 5'd6;
      6'd42: code = 5'd11;  6'd43: code = 5'd15;  6'd44: code = 5'd18;
      6'd45: code = 5'd28;  6'd46: code = 5'd12;  6'd47: code = 5'd24;
      6'd48: code = 5'd22;  6'd49: code = 5'd23;  6'd50: code = 5'd10;
      6'd51: code = 5'd5;   6'd52: code = 5'd16;  6'd53: code = 5'd7;
      6'd54: code = 5'd30;  6'd55: code = 5'd19;  6'd56: code = 5'd29;
      6'd57: code = 5'd21;  6'd58: code = 5'd17;
      default: code = 5'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[design/rttyf_if.sv]
// Valid/ready channel interfaces for the request and code streams of the RTTY framer.
`default_nettype none

interface rttyf_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] ascii_char;

  modport source (output valid, output req_type, output ascii_char, input ready);
  modport sink   (input valid, input req_type, input ascii_char, output ready);
endinterface

interface rttyf_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] ita2_code;
  logic [7:0] line_frame;
  logic       last_code;

  modport source (output valid, output ita2_code, output line_frame, output last_code,
                  input ready);
  modport sink   (input valid, input ita2_code, input line_frame, input last_code,
                  output ready);
endinterface

`default_nettype wire

[design/rttyf_front.sv]
// Front end: classifies each request, tracks the shift state and builds a code job.
`default_nettype none

module rttyf_front
  import rttyf_pkg::*;
#(
  parameter int unsigned IdleCodes = IDLE_CODES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       req_type,
  input  wire logic [7:0] ascii_char,
  output logic            job_valid,
  output rttyf_job_t      job
);

  logic       figures_r, figures_nxt;
  logic [7:0] folded;
  logic       shift_due;
  logic [4:0] shift_code;
  logic       char_ok;
  logic [4:0] char_code;
  logic [5:0] tbl_idx;

  always_comb begin
    folded = ascii_char;
    if (ascii_char >= CHAR_LOW_A && ascii_char <= CHAR_LOW_Z) begin
      folded = ascii_char & CASE_MASK;
    end
    tbl_idx   = 6'(folded - TABLE_BASE);
    char_ok   = (folded >= TABLE_BASE) && (folded < TABLE_END);
    char_code = ita2_lookup(tbl_idx);
  end

  always_comb begin
    figures_nxt = figures_r;
    shift_due   = 1'b0;
    shift_code  = CODE_FIGURES;
    job_valid   = 1'b1;
    job         = '{code_a: CODE_LETTERS, rep: REP_W'(IdleCodes), has_b: 1'b0,
                    code_b: char_code};
    if (req_type == REQ_IDLE) begin
      figures_nxt = 1'b0;
    end else if (ascii_char == CHAR_CR) begin
      job.code_a = CODE_CR;
      job.rep    = REP_W'(1);
    end else if (ascii_char == CHAR_LF) begin
      job.code_a = CODE_LF;
      job.rep    = REP_W'(1);
    end else begin
      if (folded == CHAR_SPACE) begin
        figures_nxt = 1'b0;
      end else if (folded < CHAR_AT || folded[7]) begin
        shift_due   = !figures_r;
        shift_code  = CODE_FIGURES;
        figures_nxt = 1'b1;
      end else begin
        shift_due   = figures_r;
        shift_code  = CODE_LETTERS;
        figures_nxt = 1'b0;
      end
      job.rep = REP_W'(1);
      if (shift_due) begin
        job.code_a = shift_code;
        job.has_b  = char_ok;
      end else begin
        job.code_a = char_code;
        job_valid  = char_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      figures_r <= 1'b0;
    end else if (accept) begin
      figures_r <= figures_nxt;
    end
  end

endmodule

`default_nettype wire

[design/rttyf_queue.sv]
// Small job queue that decouples the classifier from the code sequencer.
`default_nettype none

module rttyf_queue
  import rttyf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  rttyf_job_t      push_job,
  output logic            not_full,
  input  wire logic       pop,
  output logic            not_empty,
  output rttyf_job_t      head_job
);

  localparam int unsigned PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(Q_DEPTH + 1);

  rttyf_job_t          slots_r [Q_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;

  assign not_full  = (count_r != CntW'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = slots_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Q_DEPTH - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/rttyf_back.sv]
// Back end: expands queued jobs into one framed code per cycle behind an output register.
`default_nettype none

module rttyf_back
  import rttyf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  rttyf_job_t      q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_code,
  output logic [7:0]      out_frame,
  output logic            out_last
);

  logic       busy_r, busy_nxt;
  rttyf_job_t job_r, job_nxt;
  rttyf_job_t cur;
  logic       out_valid_r, out_valid_nxt;
  logic [4:0] code_r, code_nxt;
  logic       last_r, last_nxt;
  logic       adv, fire;
  logic       emit_last;
  logic [4:0] emit_code;

  assign adv = !out_valid_r || out_ready;
  assign cur = busy_r ? job_r : q_head;
  assign fire = adv && (busy_r || q_valid);
  assign q_pop = fire && !busy_r;

  always_comb begin
    job_nxt = cur;
    if (cur.rep != '0) begin
      emit_code   = cur.code_a;
      emit_last   = (cur.rep == REP_W'(1)) && !cur.has_b;
      job_nxt.rep = cur.rep - 1'b1;
    end else begin
      emit_code = cur.code_b;
      emit_last = 1'b1;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    last_nxt      = last_r;
    if (fire) begin
      busy_nxt      = !emit_last;
      out_valid_nxt = 1'b1;
      code_nxt      = emit_code;
      last_nxt      = emit_last;
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      job_r <= job_nxt;
    end
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_code  = code_r;
  assign out_frame = {2'b11, code_r, 1'b0};
  assign out_last  = last_r;

endmodule

`default_nettype wire

[design/ascii_to_ita2_rtty_framer.sv]
// Top level of the ASCII to ITA2 RTTY framer: front end, job queue and code sequencer.
//
//   Channel  Direction  Payload                                 Handshake
//   in_ch    sink       req_type[0:0], ascii_char[7:0]          valid / ready
//   out_ch   source     ita2_code[4:0], line_frame[7:0],        valid / ready
//                       last_code[0:0]
//
// An item is accepted on any cycle with a free queue slot, so requests can
// arrive back to back. The sequencer sends one framed code per cycle while
// the output is not stalled: a character item yields one or two codes (shift
// code plus character), an idle item yields IDLE_CODES Letters codes, and an
// item that maps to no code yields none. The first code of an item passes
// through a queue slot and then the output register, after any earlier codes.
// Reset is synchronous and empties the queue and output register and sets the
// letters shift. A stalled output holds its code, and input stalls only when
// the two-entry queue fills.
`default_nettype none

module ascii_to_ita2_rtty_framer
  import rttyf_pkg::*;
#(
  parameter int unsigned IDLE_CODES = IDLE_CODES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  rttyf_in_if.sink     in_ch,
  rttyf_out_if.source  out_ch
);

  logic       in_accept;
  logic       q_not_full;
  logic       q_not_empty;
  logic       job_valid;
  logic       q_pop;
  rttyf_job_t new_job;
  rttyf_job_t head_job;

  // Items are taken whenever the queue has room; the front end always decides
  // within the accepting cycle, so ready only reflects queue space.
  assign in_ch.ready = q_not_full;
  assign in_accept   = in_ch.valid && q_not_full;

  rttyf_front #(
    .IdleCodes (IDLE_CODES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .req_type   (in_ch.req_type),
    .ascii_char (in_ch.ascii_char),
    .job_valid  (job_valid),
    .job        (new_job)
  );

  // Items that produce no code (bytes outside the table other than CR and LF, when
  // no shift is due) still update the shift state but never enter the queue.
  rttyf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && job_valid),
    .push_job  (new_job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // The sequencer works directly from the queue head for the first code of a
  // job and keeps the remainder locally, so consecutive jobs flow without gaps.
  rttyf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_head    (head_job),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_code  (out_ch.ita2_code),
    .out_frame (out_ch.line_frame),
    .out_last  (out_ch.last_code)
  );

endmodule

`default_nettype wire

[design/rttyf_checker.sv]
// Port-level checker of the RTTY framer and its bind to the top level.
`default_nettype none

module rttyf_checker
  import rttyf_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] ita2_code,
  input wire logic [7:0] line_frame,
  input wire logic       last_code
);

  logic fig_open_r;

  // Remembers that a Figures code was sent that is not the end of its item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fig_open_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      fig_open_r <= (ita2_code == CODE_FIGURES) && !last_code;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ita2_code) && $stable(last_code))
    else $error("stalled code changed");

  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> line_frame == {2'b11, ita2_code, 1'b0})
    else $error("line frame does not match code");

  a_fig_then_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fig_open_r |->
      last_code && ita2_code != CODE_FIGURES && ita2_code != CODE_LETTERS)
    else $error("Figures shift not followed by a final character code");

  a_crlf_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (ita2_code == CODE_CR || ita2_code == CODE_LF) |-> last_code)
    else $error("CR or LF code not final");

endmodule

bind ascii_to_ita2_rtty_framer rttyf_checker u_rttyf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .ita2_code  (out_ch.ita2_code),
  .line_frame (out_ch.line_frame),
  .last_code  (out_ch.last_code)
);

`default_nettype wire
